>>> hw/rtl/btlpm_pkg.sv
// Package for the binary trie longest prefix match: sizes, command codes, node layout, controller states.
`timescale 1ns / 1ps
package btlpm_pkg;

  // Trie node pool and route table sizes
  localparam int NODE_COUNT  = 4096;
  localparam int ROUTE_COUNT = 1024;
  localparam int NODE_AW     = $clog2(NODE_COUNT);
  localparam int USED_W      = NODE_AW + 1;
  localparam int INDEX_W     = 10;
  localparam int KEY_W       = 32;
  localparam int LVL_W       = $clog2(KEY_W + 1);

  // Stream widths
  localparam int IN_DATA_W   = 112;
  localparam int OUT_DATA_W  = 16;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // One trie node as held in the node memory
  typedef struct packed {
    logic [NODE_AW-1:0] child1;
    logic [NODE_AW-1:0] child0;
    logic               marked;
    logic [INDEX_W-1:0] route;
  } node_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FRESH,
    ST_DONE
  } state_t;

endpackage

>>> hw/rtl/binary_trie_longest_prefix_match.sv
// Top level: IPv4 routing trie with insert and longest prefix lookup over a node memory.
`timescale 1ns / 1ps
//
//  Channel  Direction  Handshake            Payload
//  in_      slave      in_tvalid/in_tready  tuser: command; tdata: prefix, mask, index, address
//  out_     master     out_tvalid/out_tready tdata: found, best_index, pool_full
//
//  The accepting cycle issues the root read; then each node visited (the root and up to 32
//  levels below it) takes one node memory access; then the result is handed to the output
//  register. An insert whose index is out of range goes straight to the result.
//  One item is in work at a time; the next is taken once the result sits in the output
//  register. A stalled output holds the finished result and blocks the next item.
//  Reset leaves only the root allocated (read as empty until first written); no clearing pass.
//
module binary_trie_longest_prefix_match (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [31:0] route_prefix, [63:32] route_mask, [73:64] route_index,
  // [105:74] lookup_address, [111:106] zero
  input  logic [btlpm_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] command
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] found, [10:1] best_index, [11] pool_full, [15:12] zero
  output logic [btlpm_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import btlpm_pkg::*;

  // Controller and walk registers
  state_t              state_r, state_nxt;
  logic                cmd_r;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [KEY_W-1:0]    mask_r, mask_nxt;
  logic [INDEX_W-1:0]  idx_r;
  logic [NODE_AW-1:0]  cur_r, cur_nxt;
  logic [USED_W-1:0]   used_r, used_nxt;
  logic [LVL_W-1:0]    lvl_r, lvl_nxt;
  logic                hit_r, hit_nxt;
  logic [INDEX_W-1:0]  best_r, best_nxt;
  logic                full_r, full_nxt;
  logic                root_valid_r;
  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Node memory port
  node_t               mem [NODE_COUNT];
  node_t               rd_data_r;
  logic                rd_en;
  logic [NODE_AW-1:0]  rd_addr;
  logic                wr_en;
  logic [NODE_AW-1:0]  wr_addr;
  node_t               wr_data;

  // Decoded walk conditions
  node_t               node_q;
  logic                accept;
  logic                bit_sel;
  logic [NODE_AW-1:0]  child_sel;
  logic                pool_empty;
  logic                idx_ok;
  logic                out_free;

  assign accept     = in_tvalid && in_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  // Root reads as empty until first written
  assign node_q     = (cur_r == '0 && !root_valid_r) ? node_t'('0) : rd_data_r;
  assign bit_sel    = key_r[KEY_W-1];
  assign child_sel  = bit_sel ? node_q.child1 : node_q.child0;
  assign pool_empty = (used_r >= USED_W'(NODE_COUNT));
  assign idx_ok     = (32'(in_tdata[73:64]) < 32'(ROUTE_COUNT));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser == CMD_INSERT && !idx_ok) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (cmd_r == CMD_LOOKUP) begin
          if (lvl_r == LVL_W'(KEY_W) || child_sel == '0) begin
            state_nxt = ST_DONE;
          end
        end else if (!mask_r[KEY_W-1] || (child_sel == '0 && pool_empty)) begin
          state_nxt = ST_DONE;
        end else if (child_sel == '0) begin
          state_nxt = ST_FRESH;
        end
      end
      ST_FRESH: begin
        if (!mask_r[KEY_W-1] || pool_empty) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    key_nxt  = key_r;
    mask_nxt = mask_r;
    cur_nxt  = cur_r;
    used_nxt = used_r;
    lvl_nxt  = lvl_r;
    hit_nxt  = hit_r;
    best_nxt = best_r;
    full_nxt = full_r;
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = cur_r;
    wr_data  = node_q;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // Start every walk at the root
          rd_en    = 1'b1;
          rd_addr  = '0;
          cur_nxt  = '0;
          lvl_nxt  = '0;
          hit_nxt  = 1'b0;
          best_nxt = '0;
          full_nxt = 1'b0;
          key_nxt  = (in_tuser == CMD_LOOKUP) ? in_tdata[105:74] : in_tdata[31:0];
          mask_nxt = in_tdata[63:32];
        end
      end
      ST_WALK: begin
        if (cmd_r == CMD_LOOKUP) begin
          // Deepest marked node on the path wins
          if (node_q.marked) begin
            hit_nxt  = 1'b1;
            best_nxt = node_q.route;
          end
          if (!(lvl_r == LVL_W'(KEY_W) || child_sel == '0)) begin
            rd_en   = 1'b1;
            rd_addr = child_sel;
            cur_nxt = child_sel;
            lvl_nxt = lvl_r + 1'b1;
            key_nxt = {key_r[KEY_W-2:0], 1'b0};
          end
        end else if (!mask_r[KEY_W-1]) begin
          // Prefix end: mark existing node, children kept
          wr_en          = 1'b1;
          wr_data.marked = 1'b1;
          wr_data.route  = idx_r;
        end else if (child_sel != '0) begin
          rd_en    = 1'b1;
          rd_addr  = child_sel;
          cur_nxt  = child_sel;
          key_nxt  = {key_r[KEY_W-2:0], 1'b0};
          mask_nxt = {mask_r[KEY_W-2:0], 1'b0};
        end else if (pool_empty) begin
          full_nxt = 1'b1;
        end else begin
          // Link a new node; from here on every node is known to be empty
          wr_en = 1'b1;
          if (bit_sel) begin
            wr_data.child1 = used_r[NODE_AW-1:0];
          end else begin
            wr_data.child0 = used_r[NODE_AW-1:0];
          end
          cur_nxt  = used_r[NODE_AW-1:0];
          used_nxt = used_r + 1'b1;
          key_nxt  = {key_r[KEY_W-2:0], 1'b0};
          mask_nxt = {mask_r[KEY_W-2:0], 1'b0};
        end
      end
      ST_FRESH: begin
        // Current node freshly allocated: contents are zero, no read needed
        wr_en   = 1'b1;
        wr_data = node_t'('0);
        if (!mask_r[KEY_W-1]) begin
          wr_data.marked = 1'b1;
          wr_data.route  = idx_r;
        end else if (pool_empty) begin
          full_nxt = 1'b1;
        end else begin
          if (bit_sel) begin
            wr_data.child1 = used_r[NODE_AW-1:0];
          end else begin
            wr_data.child0 = used_r[NODE_AW-1:0];
          end
          cur_nxt  = used_r[NODE_AW-1:0];
          used_nxt = used_r + 1'b1;
          key_nxt  = {key_r[KEY_W-2:0], 1'b0};
          mask_nxt = {mask_r[KEY_W-2:0], 1'b0};
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Node memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      used_r       <= USED_W'(1);
      root_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      if (wr_en && wr_addr == '0) begin
        root_valid_r <= 1'b1;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Walk payload
  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    mask_r <= mask_nxt;
    cur_r  <= cur_nxt;
    lvl_r  <= lvl_nxt;
    hit_r  <= hit_nxt;
    best_r <= best_nxt;
    full_r <= full_nxt;
    if (accept) begin
      cmd_r <= in_tuser;
      idx_r <= in_tdata[73:64];
    end
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= {4'b0,
                     (cmd_r == CMD_INSERT) && full_r,
                     (cmd_r == CMD_LOOKUP && hit_r) ? best_r : INDEX_W'(0),
                     (cmd_r == CMD_LOOKUP) && hit_r};
    end
  end

`ifndef SYNTHESIS
  // Allocation count stays within the pool
  assert property (@(posedge clk) disable iff (!rst_n)
    used_r >= USED_W'(1) && used_r <= USED_W'(NODE_COUNT))
    else $error("node count out of range");

  // Allocation only while an insert walks
  assert property (@(posedge clk) disable iff (!rst_n)
    used_r != $past(used_r) |-> cmd_r == CMD_INSERT)
    else $error("node allocated outside insert");

  // Fresh nodes are never read back
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FRESH |-> !rd_en && wr_en)
    else $error("fresh node walk touched memory read");

  // Lookups never write the trie
  assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> cmd_r == CMD_INSERT && (state_r == ST_WALK || state_r == ST_FRESH))
    else $error("trie written outside insert walk");

  // A result never claims both a hit and pool exhaustion
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[0] && out_data_r[11]))
    else $error("found and pool_full both set");
`endif

endmodule
